// File: design/rtm_pkg.sv
// ---------------------------------------------------------------------------
// rtm_pkg
// Types, codes and defaults shared by the route table merge block.
// ---------------------------------------------------------------------------
package rtm_pkg;

  localparam int NODES_DEF  = 256;
  localparam int ROUTES_DEF = 8;

  // Item function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_MERGE = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Result action codes
  localparam logic [2:0] ACT_SKIP    = 3'd0;
  localparam logic [2:0] ACT_INSERT  = 3'd1;
  localparam logic [2:0] ACT_REPLACE = 3'd2;
  localparam logic [2:0] ACT_DROP    = 3'd3;
  localparam logic [2:0] ACT_DONE    = 3'd4;

  // Configuration register indexes
  localparam logic [0:0] REG_SELF = 1'd0;
  localparam logic [0:0] REG_VIA  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_NODE,
    ST_GWRD,
    ST_GWWAIT,
    ST_SCAN,
    ST_SCANWAIT,
    ST_DECIDE,
    ST_SHIFT,
    ST_SHIFTWAIT,
    ST_WRITE,
    ST_RESULT
  } rtm_state_t;

endpackage

// File: design/rtm_route_mem.sv
// ---------------------------------------------------------------------------
// rtm_route_mem
// Route entry store: gateway and trip time, one write and one read port,
// registered read data.
// ---------------------------------------------------------------------------
module rtm_route_mem #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_gw,
  input  logic [31:0]   wr_time,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_gw,
  output logic [31:0]   rd_time
);

  logic [39:0] mem [2**AW];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_gw, wr_time};
    end
    {rd_gw, rd_time} <= mem[rd_addr];
  end

endmodule

// File: design/rtm_node_mem.sv
// ---------------------------------------------------------------------------
// rtm_node_mem
// Per-node status store: route count, void flag and update flag.
// ---------------------------------------------------------------------------
module rtm_node_mem #(
  parameter int NW = 8,
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [NW-1:0] wr_addr,
  input  logic [CW+1:0] wr_data,
  input  logic [NW-1:0] rd_addr,
  output logic [CW+1:0] rd_data
);

  logic [CW+1:0] mem [2**NW];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/route_table_merge.sv
// ---------------------------------------------------------------------------
// route_table_merge
// Per-node route table with load, merge, close and read items; merges insert in sorted order.
// ---------------------------------------------------------------------------
// After reset the block sweeps the node status memory and holds busy high
// meanwhile. A load, close or read item passes through the node, scan,
// decide and write states before its result is shown, and a merge first
// reads the destination status and the gateway status and route, then
// scans the entries of the destination one memory read at a time; a sorted
// insert then shifts the tail up one entry at a time through the single
// read port of the route memory. An item whose destination lies outside
// the table goes from the node state straight to its result. One result
// per item is shown for one cycle with done high; it cannot be held off,
// and busy stays high until it has been shown, so the next item is
// accepted the cycle after.
module route_table_merge #(
  parameter int NODES  = rtm_pkg::NODES_DEF,
  parameter int ROUTES = rtm_pkg::ROUTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  dest,
  input  logic [2:0]  rank,
  input  logic [7:0]  gateway,
  input  logic [31:0] trip_time,
  input  logic        new_is_neighbor,
  input  logic        new_is_self,
  input  logic        new_is_void,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  action,
  output logic [2:0]  slot,
  output logic [7:0]  mapped_gateway,
  output logic [31:0] read_time,
  output logic [3:0]  route_total,
  output logic        node_empty,
  output logic        node_updated,
  output logic [15:0] merge_total
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int RW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int CW = $clog2(ROUTES + 1);
  localparam int AW = NW + RW;

  rtm_pkg::rtm_state_t state, state_next;

  logic [7:0]  self_node, via_node;
  logic [1:0]  i_func;
  logic [7:0]  i_dest, i_gw;
  logic [2:0]  i_rank;
  logic [31:0] i_time;
  logic        i_nb, i_nself, i_nvoid;
  logic [CW-1:0] cnt;
  logic        nvoid_f, nupd_f;
  logic [7:0]  mgw;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic        found;
  logic        last_ge;
  logic [NW:0] clr;
  logic [15:0] changes;
  logic [2:0]  r_action;
  logic [2:0]  r_slot;
  logic [31:0] r_time;
  logic [7:0]  r_gw;

  logic          rm_we;
  logic [AW-1:0] rm_wa, rm_ra;
  logic [7:0]    rm_wgw, rm_rgw;
  logic [31:0]   rm_wt, rm_rt;
  logic          nm_we;
  logic [NW-1:0] nm_wa, nm_ra;
  logic [CW+1:0] nm_wd, nm_rd;

  logic          dest_ok, gw_ok, skip;
  logic [NW-1:0] dnode, gnode;

  assign dest_ok = ({24'd0, i_dest} < NODES);
  assign gw_ok   = ({24'd0, i_gw} < NODES);
  assign dnode   = NW'(i_dest);
  assign gnode   = NW'(i_gw);
  assign skip    = (i_dest == self_node) || i_nself || i_nvoid || (i_gw == self_node);
  assign busy    = (state != rtm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  rtm_route_mem #(.AW(AW)) u_route (
    .clk(clk), .wr_en(rm_we), .wr_addr(rm_wa), .wr_gw(rm_wgw), .wr_time(rm_wt),
    .rd_addr(rm_ra), .rd_gw(rm_rgw), .rd_time(rm_rt)
  );

  rtm_node_mem #(.NW(NW), .CW(CW)) u_node (
    .clk(clk), .wr_en(nm_we), .wr_addr(nm_wa), .wr_data(nm_wd),
    .rd_addr(nm_ra), .rd_data(nm_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtm_pkg::ST_IDLE:   if (start) state_next = rtm_pkg::ST_NODE;
      rtm_pkg::ST_CLEAR:  if (clr == (NW+1)'(NODES - 1)) state_next = rtm_pkg::ST_IDLE;
      rtm_pkg::ST_NODE: begin
        if (!dest_ok) state_next = rtm_pkg::ST_RESULT;
        else if (i_func == rtm_pkg::FUNC_MERGE) state_next = rtm_pkg::ST_GWRD;
        else state_next = rtm_pkg::ST_SCAN;
      end
      rtm_pkg::ST_GWRD:   state_next = rtm_pkg::ST_GWWAIT;
      rtm_pkg::ST_GWWAIT: state_next = rtm_pkg::ST_SCAN;
      rtm_pkg::ST_SCAN:   state_next = rtm_pkg::ST_SCANWAIT;
      rtm_pkg::ST_SCANWAIT: begin
        if (i_func != rtm_pkg::FUNC_MERGE || skip || idx >= cnt)
          state_next = rtm_pkg::ST_DECIDE;
        else state_next = rtm_pkg::ST_SCAN;
      end
      rtm_pkg::ST_DECIDE: begin
        if (i_func == rtm_pkg::FUNC_MERGE && !skip && {1'b0, i_rank} >= 4'(cnt)
            && cnt < CW'(ROUTES) && cnt > pos)
          state_next = rtm_pkg::ST_SHIFT;
        else state_next = rtm_pkg::ST_WRITE;
      end
      rtm_pkg::ST_SHIFT:     state_next = rtm_pkg::ST_SHIFTWAIT;
      rtm_pkg::ST_SHIFTWAIT: state_next = (idx - 1'b1 > pos) ? rtm_pkg::ST_SHIFT
                                                            : rtm_pkg::ST_WRITE;
      rtm_pkg::ST_WRITE:  state_next = rtm_pkg::ST_RESULT;
      rtm_pkg::ST_RESULT: state_next = rtm_pkg::ST_IDLE;
      default:            state_next = rtm_pkg::ST_IDLE;
    endcase
  end

  // Memory addresses and write strobes
  always_comb begin
    rm_ra  = {dnode, RW'(idx)};
    rm_we  = 1'b0;
    rm_wa  = {dnode, RW'(idx)};
    rm_wgw = i_gw;
    rm_wt  = i_time;
    nm_ra  = dnode;
    nm_we  = 1'b0;
    nm_wa  = dnode;
    nm_wd  = {cnt, nvoid_f, nupd_f};
    unique case (state)
      rtm_pkg::ST_CLEAR: begin
        nm_we = 1'b1;
        nm_wa = clr[NW-1:0];
        nm_wd = {CW'(0), 1'b1, 1'b0};
      end
      rtm_pkg::ST_GWRD: begin
        nm_ra = gnode;
        rm_ra = {gnode, RW'(0)};
      end
      rtm_pkg::ST_SCAN: begin
        if (i_func == rtm_pkg::FUNC_READ) rm_ra = {dnode, RW'(i_rank)};
      end
      rtm_pkg::ST_SHIFT:  rm_ra = {dnode, RW'(idx - 1'b1)};
      rtm_pkg::ST_SHIFTWAIT: begin
        rm_we  = 1'b1;
        rm_wa  = {dnode, RW'(idx)};
        rm_wgw = rm_rgw;
        rm_wt  = rm_rt;
      end
      rtm_pkg::ST_WRITE: begin
        nm_we = dest_ok;
        if (r_action == rtm_pkg::ACT_INSERT || r_action == rtm_pkg::ACT_REPLACE) begin
          rm_we  = 1'b1;
          rm_wa  = {dnode, RW'(r_slot)};
          rm_wgw = (i_func == rtm_pkg::FUNC_LOAD) ? i_gw : mgw;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rtm_pkg::ST_CLEAR;
      clr       <= '0;
      self_node <= '0;
      via_node  <= '0;
      changes   <= '0;
    end else begin
      state <= state_next;
      if (state == rtm_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rtm_pkg::REG_SELF: self_node <= cfg_data;
          rtm_pkg::REG_VIA:  via_node  <= cfg_data;
          default: ;
        endcase
      end
      if (state == rtm_pkg::ST_WRITE && i_func == rtm_pkg::FUNC_MERGE
          && (r_action == rtm_pkg::ACT_INSERT || r_action == rtm_pkg::ACT_REPLACE)
          && changes != 16'hFFFF)
        changes <= changes + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rtm_pkg::ST_IDLE: begin
        i_func <= func; i_dest <= dest; i_rank <= rank; i_gw <= gateway;
        i_time <= trip_time; i_nb <= new_is_neighbor; i_nself <= new_is_self;
        i_nvoid <= new_is_void;
        r_action <= rtm_pkg::ACT_SKIP; r_slot <= '0; r_gw <= '0; r_time <= '0;
        idx <= '0; pos <= '0; found <= 1'b0; last_ge <= 1'b0;
      end
      rtm_pkg::ST_GWRD: begin
        {cnt, nvoid_f, nupd_f} <= nm_rd;
      end
      rtm_pkg::ST_GWWAIT: begin
        // node status of the gateway now valid; dest status was latched
        if (i_nb || !gw_ok || nm_rd[1] || nm_rd[CW+1:2] == '0) mgw <= via_node;
        else mgw <= rm_rgw;
      end
      rtm_pkg::ST_SCAN: begin
        // dest status read is addressed from the previous cycle on
        {cnt, nvoid_f, nupd_f} <= nm_rd;
      end
      rtm_pkg::ST_SCANWAIT: begin
        if (i_func == rtm_pkg::FUNC_MERGE && idx < cnt) begin
          if (rm_rt <= i_time && !found) pos <= idx + 1'b1;
          else found <= 1'b1;
          if (rm_rt > i_time && !found) r_slot <= 3'(idx);
          if (idx == cnt - 1'b1) last_ge <= (rm_rt >= i_time);
          idx <= idx + 1'b1;
        end
        if (i_func == rtm_pkg::FUNC_READ && {1'b0, i_rank} < 4'(cnt)) begin
          r_gw <= rm_rgw; r_time <= rm_rt;
        end
      end
      rtm_pkg::ST_DECIDE: begin
        idx <= cnt;
        unique case (i_func)
          rtm_pkg::FUNC_LOAD: begin
            if (cnt >= CW'(ROUTES)) r_action <= rtm_pkg::ACT_DROP;
            else begin
              r_action <= rtm_pkg::ACT_INSERT; r_slot <= 3'(cnt); r_gw <= i_gw;
              cnt <= cnt + 1'b1; nvoid_f <= 1'b0;
            end
          end
          rtm_pkg::FUNC_MERGE: begin
            if (!skip) begin
              r_gw <= mgw;
              if ({1'b0, i_rank} >= 4'(cnt)) begin
                if (cnt >= CW'(ROUTES)) r_action <= rtm_pkg::ACT_DROP;
                else begin
                  r_action <= rtm_pkg::ACT_INSERT; r_slot <= 3'(pos);
                  cnt <= cnt + 1'b1; nvoid_f <= 1'b0; nupd_f <= 1'b1;
                end
              end else if (found && last_ge) begin
                // loaded entries need not be sorted, so the last one is checked too
                r_action <= rtm_pkg::ACT_REPLACE; nupd_f <= 1'b1;
              end else r_slot <= '0;
            end
          end
          rtm_pkg::FUNC_CLOSE: begin
            r_action <= rtm_pkg::ACT_DONE;
            if (cnt == '0) begin nvoid_f <= 1'b1; nupd_f <= 1'b0; end
            else nvoid_f <= 1'b0;
          end
          default: begin
            r_action <= rtm_pkg::ACT_DONE; r_slot <= i_rank;
            if ({1'b0, i_rank} >= 4'(cnt)) r_time <= '1;
          end
        endcase
      end
      rtm_pkg::ST_SHIFTWAIT: idx <= idx - 1'b1;
      default: ;
    endcase
  end

  // Result outputs
  always_comb begin
    done           = (state == rtm_pkg::ST_RESULT);
    action         = r_action;
    slot           = r_slot;
    mapped_gateway = r_gw;
    read_time      = r_time;
    route_total    = dest_ok ? 4'(cnt) : 4'd0;
    node_empty     = dest_ok ? nvoid_f : 1'b1;
    node_updated   = dest_ok ? nupd_f : 1'b0;
    merge_total    = changes;
  end

endmodule

// File: design/rtm_checker.sv
// ---------------------------------------------------------------------------
// rtm_checker
// Port level checks of the route table merge block.
// ---------------------------------------------------------------------------
module rtm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  action,
  input logic [15:0] merge_total
);

  // A result appears only while busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result outside transaction");

  // Accepted transaction raises busy
  a_start: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accept without busy");

  // Merge count never falls
  a_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> merge_total >= $past(merge_total))
    else $error("merge count fell");

  // Legal action codes only
  a_act: assert property (@(posedge clk) disable iff (rst) done |-> action <= 3'd4)
    else $error("bad action");

endmodule

bind route_table_merge rtm_checker u_rtm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .action(action), .merge_total(merge_total)
);
